### hw/rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants for the software timer table
// Holds the table size, opcodes, result kinds, status codes and the
// sequencer state type and the result record.
// ----------------------------------------------------------------------------
`default_nettype none
package stt_pkg;
    localparam int NUM_TIMERS = 32;
    localparam int IDX_W      = $clog2(NUM_TIMERS);
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam int TIME_W     = 31;
    localparam int ENTRY_W    = 8 + 16 + TIME_W;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_ADD     = 3'd1;
    localparam logic [2:0] OP_ADD_REP = 3'd2;
    localparam logic [2:0] OP_DEL     = 3'd3;
    localparam logic [2:0] OP_DEL_SUB = 3'd4;
    localparam logic [2:0] OP_QUERY   = 3'd5;
    localparam logic [2:0] OP_FIRE    = 3'd6;
    localparam logic [2:0] OP_FIRE_ALL = 3'd7;

    localparam logic [1:0] KIND_FIRED   = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_ACK     = 2'd2;
    localparam logic [1:0] KIND_QUERY   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,   // wait for an input transfer
        S_READ,   // issue read of current slot
        S_EVAL,   // read data back: examine entry
        S_MOVE,   // read of top entry issued for a move
        S_PUT,    // write moved entry into freed slot
        S_FINAL,  // emit final result
        S_WAIT    // hold until output register drains
    } state_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        out_subscriber;
        logic [15:0]       out_tag;
        logic [TIME_W-1:0] remaining;
        logic              remaining_valid;
        logic [1:0]        status;
        logic              last;
    } result_t;
endpackage
`default_nettype wire

### hw/rtl/stt_if.sv
// ----------------------------------------------------------------------------
// stt_in_if / stt_out_if: valid/ready channels of the timer table
// One interface per direction, each with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none
interface stt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [7:0]  subscriber_id;
    logic [15:0] tag;
    logic [30:0] timer_length;
    logic [30:0] elapsed;
    modport source (output valid, opcode, subscriber_id, tag, timer_length, elapsed,
                    input ready);
    modport sink   (input valid, opcode, subscriber_id, tag, timer_length, elapsed,
                    output ready);
endinterface

interface stt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_subscriber;
    logic [15:0] out_tag;
    logic [30:0] remaining;
    logic        remaining_valid;
    logic [1:0]  status;
    logic        last;
    modport source (output valid, kind, out_subscriber, out_tag, remaining,
                    remaining_valid, status, last, input ready);
    modport sink   (input valid, kind, out_subscriber, out_tag, remaining,
                    remaining_valid, status, last, output ready);
endinterface
`default_nettype wire

### hw/rtl/stt_ram.sv
// ----------------------------------------------------------------------------
// stt_ram: generic single-port synchronous RAM
// One write or read per cycle; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### hw/rtl/software_timer_table.sv
// ----------------------------------------------------------------------------
// software_timer_table: compact table of one-shot timers
// Entries live in one RAM, packed in slots 0..count-1; removal moves the
// top entry into the freed slot.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in      | in  | opcode, subscriber_id, tag, timer_length, elapsed
//  out     | out | kind, out_subscriber, out_tag, remaining, remaining_valid,
//          |     | status, last
//
//  Each item walks the table through the single RAM port: each slot examined
//  is read, then examined (S_READ, S_EVAL); each removal adds a top read and a
//  write back (S_MOVE, S_PUT); the item then ends in S_FINAL and S_WAIT.
//  Add goes straight to S_FINAL; add replacing first searches and removes.
//  Output stalls hold the walk; one result waits in the output register.
//  Reset clears the entry count and sequencer; RAM contents need no clear.
// ----------------------------------------------------------------------------
`default_nettype none
module software_timer_table
    import stt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    stt_in_if.sink    in_ch,
    stt_out_if.source out_ch
);
    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [2:0]  op_reg;
    logic [7:0]  sub_reg;
    logic [15:0] tag_reg;
    logic [TIME_W-1:0] len_reg, dt_reg;
    logic        hit_reg, hit_next;
    logic        any_reg, any_next;
    logic [TIME_W-1:0] least_reg, least_next;
    logic        add_pend_reg, add_pend_next;
    result_t     res_reg;
    logic        oval_reg;

    // RAM port
    logic               we;
    logic [IDX_W-1:0]   addr;
    logic [ENTRY_W-1:0] wdata, rdata;
    stt_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_TIMERS)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    logic [7:0]  e_sub;
    logic [15:0] e_tag;
    logic [TIME_W-1:0] e_rem, e_new;
    assign {e_sub, e_tag, e_rem} = rdata;
    assign e_new = e_rem - dt_reg;

    logic in_xfer, out_free;
    assign out_free = !oval_reg || out_ch.ready;
    assign in_xfer  = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);

    logic [CNT_W-1:0] top_c;
    assign top_c = count_reg - CNT_W'(1);

    logic in_range, match_st;
    assign in_range = ({1'b0, idx_reg} < count_reg);
    assign match_st = (e_sub == sub_reg) && ((op_reg == OP_DEL_SUB) || (e_tag == tag_reg));

    // emit request from combinational control
    logic    emit;
    result_t emit_res;

    // next state and RAM control
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        any_next      = any_reg;
        least_next    = least_reg;
        add_pend_next = add_pend_reg;
        we    = 1'b0;
        addr  = idx_reg;
        wdata = rdata;
        emit  = 1'b0;
        emit_res = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    idx_next = '0;
                    hit_next = 1'b0;
                    any_next = 1'b0;
                    least_next = '0;
                    add_pend_next = (in_ch.opcode == OP_ADD_REP);
                    if (in_ch.opcode == OP_ADD)
                        state_next = S_FINAL;
                    else
                        state_next = S_READ;
                end
            end
            S_READ:
            begin
                addr = idx_reg;
                if (in_range)
                    state_next = S_EVAL;
                else
                    state_next = S_FINAL;
            end
            S_EVAL:
            begin
                case (op_reg)
                    OP_TICK:
                    begin
                        if (dt_reg > e_rem)
                        begin
                            if (out_free)
                            begin
                                emit = 1'b1;
                                emit_res.kind = KIND_FIRED;
                                emit_res.out_subscriber = e_sub;
                                emit_res.out_tag = e_tag;
                                state_next = S_MOVE;
                            end
                        end
                        else
                        begin
                            we = 1'b1;
                            wdata = {e_sub, e_tag, e_new};
                            if (!any_reg || e_new < least_reg)
                            begin
                                least_next = e_new;
                                any_next = 1'b1;
                            end
                            idx_next = idx_reg + IDX_W'(1);
                            state_next = (idx_reg == IDX_W'(top_c)) ? S_FINAL : S_READ;
                        end
                    end
                    OP_FIRE_ALL:
                    begin
                        if (out_free)
                        begin
                            emit = 1'b1;
                            emit_res.kind = KIND_FIRED;
                            emit_res.out_subscriber = e_sub;
                            emit_res.out_tag = e_tag;
                            idx_next = idx_reg + IDX_W'(1);
                            state_next = (idx_reg == IDX_W'(top_c)) ? S_FINAL : S_READ;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (match_st)
                        begin
                            hit_next = 1'b1;
                            least_next = e_rem;
                            state_next = S_FINAL;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                            state_next = (idx_reg == IDX_W'(top_c)) ? S_FINAL : S_READ;
                        end
                    end
                    default:
                    begin
                        // delete one, delete subscriber, fire now, add replacing
                        if (match_st)
                        begin
                            hit_next = 1'b1;
                            state_next = S_MOVE;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                            state_next = (idx_reg == IDX_W'(top_c)) ? S_FINAL : S_READ;
                        end
                    end
                endcase
            end
            S_MOVE:
            begin
                // read top entry
                addr = IDX_W'(top_c);
                state_next = S_PUT;
            end
            S_PUT:
            begin
                // write top entry into freed slot and shrink
                we = 1'b1;
                addr = idx_reg;
                wdata = rdata;
                count_next = top_c;
                if (op_reg == OP_TICK || op_reg == OP_DEL_SUB)
                    state_next = S_READ;
                else
                    state_next = S_FINAL;
            end
            S_FINAL:
            begin
                if (add_pend_reg)
                begin
                    add_pend_next = 1'b0;
                end
                else if (out_free)
                begin
                    emit = 1'b1;
                    emit_res.last = 1'b1;
                    emit_res.out_subscriber = sub_reg;
                    emit_res.out_tag = tag_reg;
                    emit_res.kind = KIND_ACK;
                    state_next = S_WAIT;
                    case (op_reg)
                        OP_TICK:
                        begin
                            emit_res.kind = KIND_SUMMARY;
                            emit_res.out_subscriber = '0;
                            emit_res.out_tag = '0;
                            emit_res.remaining = least_reg;
                            emit_res.remaining_valid = any_reg;
                        end
                        OP_ADD, OP_ADD_REP:
                        begin
                            if (count_reg >= CNT_W'(NUM_TIMERS))
                                emit_res.status = ST_FULL;
                            else
                            begin
                                we = 1'b1;
                                addr = IDX_W'(count_reg);
                                wdata = {sub_reg, tag_reg, len_reg};
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DEL:
                            emit_res.status = hit_reg ? ST_OK : ST_NOT_FOUND;
                        OP_DEL_SUB:
                        begin
                            emit_res.out_tag = '0;
                            emit_res.status = hit_reg ? ST_OK : ST_NOT_FOUND;
                        end
                        OP_QUERY:
                        begin
                            emit_res.kind = KIND_QUERY;
                            emit_res.remaining = hit_reg ? least_reg : '0;
                            emit_res.remaining_valid = hit_reg;
                            emit_res.status = hit_reg ? ST_OK : ST_NOT_FOUND;
                        end
                        OP_FIRE:
                        begin
                            emit_res.kind = hit_reg ? KIND_FIRED : KIND_ACK;
                            emit_res.status = hit_reg ? ST_OK : ST_NOT_FOUND;
                        end
                        default:
                            count_next = '0;
                    endcase
                end
            end
            S_WAIT:
            begin
                if (!oval_reg || out_ch.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            oval_reg     <= 1'b0;
            add_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            add_pend_reg <= add_pend_next;
            if (emit)
                oval_reg <= 1'b1;
            else if (out_ch.ready)
                oval_reg <= 1'b0;
        end
    end

    // hold item fields, walk state and the result register
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        hit_reg   <= hit_next;
        any_reg   <= any_next;
        least_reg <= least_next;
        if (in_xfer)
        begin
            op_reg  <= in_ch.opcode;
            sub_reg <= in_ch.subscriber_id;
            tag_reg <= in_ch.tag;
            len_reg <= in_ch.timer_length;
            dt_reg  <= in_ch.elapsed;
        end
        if (emit)
            res_reg <= emit_res;
    end

    assign out_ch.valid           = oval_reg;
    assign out_ch.kind            = res_reg.kind;
    assign out_ch.out_subscriber  = res_reg.out_subscriber;
    assign out_ch.out_tag         = res_reg.out_tag;
    assign out_ch.remaining       = res_reg.remaining;
    assign out_ch.remaining_valid = res_reg.remaining_valid;
    assign out_ch.status          = res_reg.status;
    assign out_ch.last            = res_reg.last;
endmodule
`default_nettype wire

### hw/rtl/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker: port-level checks for the software timer table
// Watches the two channels and flags protocol and ordering slips.
// ----------------------------------------------------------------------------
`default_nettype none
module stt_checker
    import stt_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    stt_in_if.sink    in_ch,
    stt_out_if.source out_ch
);
    logic busy_reg;

    // track an item whose final result is not yet transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (in_ch.valid && in_ch.ready)
            busy_reg <= 1'b1;
        else if (out_ch.valid && out_ch.ready && out_ch.last)
            busy_reg <= 1'b0;
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !in_ch.ready)
        else $error("input taken while an item is in progress");

    a_no_stray_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready |-> busy_reg)
        else $error("result with no item in progress");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.kind))
        else $error("stalled result changed");

    a_nonlast_fired: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.last |-> out_ch.kind == KIND_FIRED)
        else $error("non-final result is not a fired timer");
endmodule

bind software_timer_table stt_checker u_stt_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
);
`default_nettype wire
